// ===== hw/rtl/bitmap_frame_allocator_macros.svh =====
// Assertion macros for the bitmap frame allocator checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef BITMAP_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap_frame_allocator: assertion failed");

// next-cycle implication, disabled while reset is low
`define BFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap_frame_allocator: assertion failed");

`endif

// ===== hw/rtl/bfa_pkg.sv =====
// Shared types and constants for the bitmap frame allocator.
// No dependencies; used by the engine, the top level, the checker and the bench.
`default_nettype none

package bfa_pkg;

    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 1;
    localparam int REGION_W  = 64;
    localparam int PHYS_W    = 32;
    localparam int FRAME_SHIFT = 12;
    localparam int PHYS_IDX_W  = PHYS_W - FRAME_SHIFT;
    localparam int REGION_IDX_W = REGION_W - FRAME_SHIFT;

    localparam logic [REGION_W-1:0] FRAME_MASK = 64'h0000_0000_0000_0FFF;

    localparam logic [CFG_W-1:0] FRAME_COUNT_RST    = 17'h1_0000;
    localparam logic [CFG_W-1:0] RESERVED_COUNT_RST = 17'h0_0001;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RESERVED_COUNT = 1'b1;

    typedef enum logic [2:0] {
        MODE_INIT        = 3'd0,
        MODE_FREE_REGION = 3'd1,
        MODE_RESERVE     = 3'd2,
        MODE_ALLOC       = 3'd3,
        MODE_FREE_FRAME  = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_SET,
        OP_ALLOC
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [CFG_W-1:0] frame_count;
        logic [CFG_W-1:0] reserved_count;
    } t_cfg;

endpackage

`default_nettype wire

// ===== hw/rtl/bfa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/bfa_div.sv =====
// Frame index split into map word index and bit offset, registered once.
// No dependencies; the divisor is the map word width and must be a power of two.
`default_nettype none

module bfa_div #(
    parameter int DW      = 17,
    parameter int DIVISOR = 32,
    parameter int RW      = $clog2(DIVISOR) + 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    output logic               o_done,
    output logic      [DW-1:0] o_quot,
    output logic      [RW-1:0] o_rem
);

    localparam int SH = $clog2(DIVISOR);

    logic          r_done;
    logic [DW-1:0] r_quot;
    logic [RW-1:0] r_rem;

    // word index is a shift, bit offset the low bits; result in the cycle after start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
            if (i_start) begin
                r_quot <= i_dividend >> SH;
                r_rem  <= RW'(i_dividend[SH-1:0]);
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== hw/rtl/bfa_engine.sv =====
// Request sequencer: decodes a transaction into a frame range, then sweeps the
// map RAM word by word (read, modify, write back). Uses bfa_pkg and bfa_div.
`default_nettype none

module bfa_engine #(
    parameter int MAX_FRAMES    = 65536,
    parameter int MAP_WORD_BITS = 32,
    parameter int WORDS = (MAX_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS,
    parameter int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire bfa_pkg::t_cfg                i_cfg,
    input  wire logic                         i_start,
    input  wire logic [2:0]                   i_mode,
    input  wire logic [bfa_pkg::REGION_W-1:0] i_region_base,
    input  wire logic [bfa_pkg::REGION_W-1:0] i_region_length,
    input  wire logic [bfa_pkg::PHYS_W-1:0]   i_phys_addr,
    output logic                              o_busy,
    output logic                              o_valid,
    output logic [bfa_pkg::PHYS_W-1:0]        o_frame_addr,
    output logic                              o_found,
    output logic                              o_ram_we,
    output logic [WAW-1:0]                    o_ram_waddr,
    output logic [MAP_WORD_BITS-1:0]          o_ram_wdata,
    output logic                              o_ram_re,
    output logic [WAW-1:0]                    o_ram_raddr,
    input  wire logic [MAP_WORD_BITS-1:0]     i_ram_rdata
);

    import bfa_pkg::*;

    localparam int WB   = MAP_WORD_BITS;
    localparam int TB   = WORDS * WB;
    localparam int FW   = $clog2(TB + 1);
    localparam int FW1  = FW + 1;
    localparam int CW   = (CFG_W > FW) ? CFG_W : FW;
    localparam int CMPW = (PHYS_IDX_W > FW) ? PHYS_IDX_W : FW;
    localparam int BW   = $clog2(WB);
    localparam int RW   = $clog2(WB) + 1;
    localparam int XW   = FW + PHYS_IDX_W;

    t_state r_state, n_state;

    t_mode                   r_mode;
    logic [REGION_IDX_W-1:0] r_start_f;
    logic [REGION_IDX_W-1:0] r_end_f;
    logic [PHYS_IDX_W-1:0]   r_frame_i;

    t_op           r_op;
    logic [FW-1:0] r_lo, r_hi;

    logic           r_iss_more;
    logic [WAW-1:0] r_iss_addr;
    logic [FW-1:0]  r_iss_base;
    logic           r_pend;
    logic [WAW-1:0] r_pend_addr;
    logic [FW-1:0]  r_pend_base;

    logic              r_found;
    logic [PHYS_W-1:0] r_frame_addr;

    logic accept;
    logic [REGION_W-1:0] sum_start, sum_end;

    logic [CW-1:0] fc_w, rc_w;
    logic [FW-1:0] lim, res_n;

    logic [FW-1:0] n_lo, n_hi;
    logic          n_act;
    t_op           n_op;
    logic [REGION_IDX_W-1:0] hi52;

    logic          div_start, div_done;
    logic [FW-1:0] div_quot;
    logic [RW-1:0] div_rem;

    logic [FW1-1:0] nxt_base;
    logic           more_nxt;
    logic [WB-1:0]  mask, cand, low;
    logic [BW-1:0]  idx_off;
    logic           alloc_hit;
    logic           run_end;
    logic [FW-1:0]  hit_frame;
    logic [XW-1:0]  hit_ext;
    logic [FW1-1:0] fb;

    assign accept    = i_start && o_busy == 1'b0;
    assign sum_start = i_region_base + FRAME_MASK;
    assign sum_end   = i_region_base + i_region_length;

    // register values above the map size act as the map size
    always_comb begin
        fc_w  = CW'(i_cfg.frame_count);
        rc_w  = CW'(i_cfg.reserved_count);
        lim   = (fc_w > CW'(MAX_FRAMES)) ? FW'(MAX_FRAMES) : FW'(fc_w);
        res_n = (rc_w > CW'(MAX_FRAMES)) ? FW'(MAX_FRAMES) : FW'(rc_w);
    end

    // frame range [lo, hi) and operation for the latched transaction
    always_comb begin
        n_lo  = '0;
        n_hi  = '0;
        n_act = 1'b0;
        n_op  = OP_CLEAR;
        hi52  = (r_end_f > REGION_IDX_W'(lim)) ? REGION_IDX_W'(lim) : r_end_f;
        case (r_mode)
            MODE_INIT: begin
                n_hi  = FW'(TB);
                n_act = 1'b1;
                n_op  = OP_SET;
            end
            MODE_FREE_REGION: begin
                n_lo  = FW'(r_start_f);
                n_hi  = FW'(hi52);
                n_act = (r_start_f < hi52);
            end
            MODE_RESERVE: begin
                // frame 0 is always marked
                n_hi  = (res_n == '0) ? FW'(1) : res_n;
                n_act = 1'b1;
                n_op  = OP_SET;
            end
            MODE_ALLOC: begin
                n_hi  = lim;
                n_act = (lim != '0);
                n_op  = OP_ALLOC;
            end
            MODE_FREE_FRAME: begin
                n_lo  = FW'(r_frame_i);
                n_hi  = FW'(FW'(r_frame_i) + FW'(1));
                n_act = (CMPW'(r_frame_i) < CMPW'(lim));
            end
            default: begin
                n_act = 1'b0;
            end
        endcase
    end

    assign div_start = (r_state == ST_PREP) && n_act;

    bfa_div #(
        .DW      (FW),
        .DIVISOR (WB),
        .RW      (RW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_lo),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // word datapath: mask of frames in range for the word whose data is back
    always_comb begin
        mask = '0;
        for (int b = 0; b < WB; b++) begin
            fb      = FW1'(r_pend_base) + FW1'(b);
            mask[b] = (fb >= FW1'(r_lo)) && (fb < FW1'(r_hi));
        end
        cand = ~i_ram_rdata & mask;
        low  = cand & WB'(~cand + WB'(1));
        idx_off = '0;
        for (int b = 0; b < WB; b++) begin
            if (low[b]) begin
                idx_off = idx_off | BW'(b);
            end
        end
        alloc_hit = (r_state == ST_RUN) && r_pend && (r_op == OP_ALLOC) && (cand != '0);
        hit_frame = FW'(r_pend_base + FW'(idx_off));
        hit_ext   = XW'(hit_frame);
        nxt_base  = FW1'(r_iss_base) + FW1'(WB);
        more_nxt  = (nxt_base < FW1'(r_hi)) && (r_iss_addr != WAW'(WORDS - 1));
        run_end   = alloc_hit || !r_iss_more;
    end

    always_comb begin
        o_ram_re    = (r_state == ST_RUN) && r_iss_more;
        o_ram_raddr = r_iss_addr;
        o_ram_we    = (r_state == ST_RUN) && r_pend && (r_op != OP_ALLOC || alloc_hit);
        o_ram_waddr = r_pend_addr;
        case (r_op)
            OP_CLEAR: o_ram_wdata = i_ram_rdata & ~mask;
            OP_SET:   o_ram_wdata = i_ram_rdata | mask;
            OP_ALLOC: o_ram_wdata = i_ram_rdata | low;
            default:  o_ram_wdata = i_ram_rdata;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE, ST_DONE: n_state = i_start ? ST_PREP : ST_IDLE;
            ST_PREP:          n_state = n_act ? ST_DIV : ST_DONE;
            ST_DIV:           n_state = div_done ? ST_RUN : ST_DIV;
            ST_RUN:           n_state = run_end ? ST_DONE : ST_RUN;
            default:          n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_busy  = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            ST_IDLE: o_busy = 1'b0;
            ST_DONE: begin
                o_busy  = 1'b0;
                o_valid = 1'b1;
            end
            default: o_busy = 1'b1;
        endcase
    end

    assign o_found      = r_found;
    assign o_frame_addr = r_frame_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_iss_more <= 1'b0;
            r_pend     <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_mode       <= t_mode'(i_mode);
                r_start_f    <= sum_start[REGION_W-1:FRAME_SHIFT];
                r_end_f      <= sum_end[REGION_W-1:FRAME_SHIFT];
                r_frame_i    <= i_phys_addr[PHYS_W-1:FRAME_SHIFT];
                r_found      <= 1'b0;
                r_frame_addr <= '0;
            end
            if (r_state == ST_PREP) begin
                r_lo <= n_lo;
                r_hi <= n_hi;
                r_op <= n_op;
            end
            if (r_state == ST_DIV && div_done) begin
                r_iss_addr <= WAW'(div_quot);
                r_iss_base <= FW'(r_lo - FW'(div_rem));
                r_iss_more <= 1'b1;
                r_pend     <= 1'b0;
            end
            if (r_state == ST_RUN) begin
                // the read issued alongside a hit is dropped
                r_pend      <= r_iss_more && !alloc_hit;
                r_pend_addr <= r_iss_addr;
                r_pend_base <= r_iss_base;
                if (r_iss_more) begin
                    r_iss_addr <= WAW'(r_iss_addr + WAW'(1));
                    r_iss_base <= FW'(nxt_base);
                    r_iss_more <= more_nxt && !alloc_hit;
                end
                if (alloc_hit) begin
                    r_found      <= 1'b1;
                    r_frame_addr <= {hit_ext[PHYS_IDX_W-1:0], FRAME_SHIFT'(0)};
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_frame_allocator.sv =====
// A transaction passes through ST_PREP, ST_DIV and ST_RUN to ST_DONE; ST_RUN sweeps N map
// words (2048 for init at the default size); allocate stops at the word holding the first
// free frame. Unknown modes and empty ranges go from ST_PREP straight to ST_DONE.
// One transaction at a time, one map word per cycle through the RAM port;
// the result strobe lasts one cycle and the receiver cannot stall.
// Synchronous reset restores registers and control; the map holds nothing valid until init.
`default_nettype none

module bitmap_frame_allocator #(
    parameter int MAX_FRAMES    = 65536,
    parameter int MAP_WORD_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [bfa_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [bfa_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [2:0]                    i_mode,
    input  wire logic [bfa_pkg::REGION_W-1:0]  i_region_base,
    input  wire logic [bfa_pkg::REGION_W-1:0]  i_region_length,
    input  wire logic [bfa_pkg::PHYS_W-1:0]    i_phys_addr,
    output logic                               o_valid,
    output logic [bfa_pkg::PHYS_W-1:0]         o_frame_addr,
    output logic                               o_found
);

    import bfa_pkg::*;

    localparam int WORDS = (MAX_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;

    t_cfg r_cfg;

    logic                     ram_we, ram_re;
    logic [WAW-1:0]           ram_waddr, ram_raddr;
    logic [MAP_WORD_BITS-1:0] ram_wdata, ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_count    <= FRAME_COUNT_RST;
            r_cfg.reserved_count <= RESERVED_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_COUNT:    r_cfg.frame_count    <= i_cfg_data;
                REG_RESERVED_COUNT: r_cfg.reserved_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bfa_engine #(
        .MAX_FRAMES    (MAX_FRAMES),
        .MAP_WORD_BITS (MAP_WORD_BITS),
        .WORDS         (WORDS),
        .WAW           (WAW)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_start         (start),
        .i_mode          (i_mode),
        .i_region_base   (i_region_base),
        .i_region_length (i_region_length),
        .i_phys_addr     (i_phys_addr),
        .o_busy          (busy),
        .o_valid         (o_valid),
        .o_frame_addr    (o_frame_addr),
        .o_found         (o_found),
        .o_ram_we        (ram_we),
        .o_ram_waddr     (ram_waddr),
        .o_ram_wdata     (ram_wdata),
        .o_ram_re        (ram_re),
        .o_ram_raddr     (ram_raddr),
        .i_ram_rdata     (ram_rdata)
    );

    bfa_ram #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (WORDS),
        .AW    (WAW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/bfa_checker.sv =====
// Port-level checker for the bitmap frame allocator, bound to the top level.
// Depends on bitmap_frame_allocator_macros.svh and bfa_pkg.
`default_nettype none
`include "bitmap_frame_allocator_macros.svh"

module bfa_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic                        o_valid,
    input wire logic [bfa_pkg::PHYS_W-1:0]  o_frame_addr,
    input wire logic                        o_found
);

    // a result strobe lasts exactly one cycle
    `BFA_ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid)
    // an accepted transaction keeps the block busy in the next cycle
    `BFA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // a result follows a busy cycle
    `BFA_ASSERT_IMPL(a_valid_after_busy, i_clk, i_rst_n, o_valid, $past(busy))
    // failed or non-allocating transactions report address zero
    `BFA_ASSERT_IMPL(a_miss_zero, i_clk, i_rst_n, o_valid && !o_found, o_frame_addr == '0)
    // frame addresses are 4 KiB aligned
    `BFA_ASSERT_IMPL(a_aligned, i_clk, i_rst_n, o_valid, o_frame_addr[11:0] == 12'h000)

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_frame_addr (o_frame_addr),
    .o_found      (o_found)
);

`default_nettype wire

// ===== tb/sv/tb_bitmap_frame_allocator.sv =====
// Self-checking bench for bitmap_frame_allocator: directed requests, then random
// phases over several map sizes and reserve counts, with idle gaps on the request side.
// Depends on bfa_pkg and the bitmap_frame_allocator RTL.
module tb_bitmap_frame_allocator;
    import bfa_pkg::*;

    localparam int FRAMES_MAX  = 65536;
    localparam int WORD_BITS   = 32;
    localparam int MAP_DEPTH   = FRAMES_MAX / WORD_BITS;
    localparam int MAX_REPORTS = 10;

    // modes the block answers with an all-zero result and no map change
    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

    typedef struct {
        logic [2:0]          mode;
        logic [REGION_W-1:0] base;
        logic [REGION_W-1:0] length;
        logic [PHYS_W-1:0]   phys;
    } t_request;

    typedef struct {
        logic [PHYS_W-1:0] frame_addr;
        logic              found;
    } t_grant;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  start;
    logic                  busy;
    logic [2:0]            i_mode;
    logic [REGION_W-1:0]   i_region_base;
    logic [REGION_W-1:0]   i_region_length;
    logic [PHYS_W-1:0]     i_phys_addr;
    logic                  o_valid;
    logic [PHYS_W-1:0]     o_frame_addr;
    logic                  o_found;

    // predictor state: one bit per frame, 1 = used
    logic [WORD_BITS-1:0]  frame_used [MAP_DEPTH];
    logic [CFG_W-1:0]      cfg_frame_count;
    logic [CFG_W-1:0]      cfg_reserved_count;

    t_request              pending_requests [$];
    t_grant                pending_grants [$];
    bit                    req_taken;
    int unsigned           idle_pct;
    int                    fail_count;

    bitmap_frame_allocator uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_region_base   (i_region_base),
        .i_region_length (i_region_length),
        .i_phys_addr     (i_phys_addr),
        .o_valid         (o_valid),
        .o_frame_addr    (o_frame_addr),
        .o_found         (o_found)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned frame_limit(int unsigned v);
        return (v > FRAMES_MAX) ? FRAMES_MAX : v;
    endfunction

    function automatic void set_frame_bit(int unsigned f, logic used);
        if (f / WORD_BITS < MAP_DEPTH)
            frame_used[f / WORD_BITS][f % WORD_BITS] = used;
    endfunction

    function automatic t_grant predict_grant(t_request r);
        t_grant              g;
        logic [REGION_W-1:0] first;
        logic [REGION_W-1:0] last;
        logic [REGION_W-1:0] lo;
        logic [REGION_W-1:0] hi;
        logic [REGION_W-1:0] f;
        int unsigned         lim;
        int unsigned         idx;
        int                  w;
        int                  b;
        g.frame_addr = '0;
        g.found      = 1'b0;
        lim          = frame_limit(cfg_frame_count);
        case (r.mode)
            MODE_INIT: begin
                for (w = 0; w < MAP_DEPTH; w++)
                    frame_used[w] = '1;
            end
            MODE_FREE_REGION: begin
                first = r.base;
                last  = (r.base + r.length) & ~FRAME_MASK;
                // unaligned base rounds up, possibly wrapping through zero
                if ((first & FRAME_MASK) != '0)
                    first = (first + FRAME_MASK) & ~FRAME_MASK;
                lo = first >> FRAME_SHIFT;
                hi = last >> FRAME_SHIFT;
                if (hi > lim)
                    hi = lim;
                for (f = lo; f < hi; f++)
                    set_frame_bit(f[31:0], 1'b0);
            end
            MODE_RESERVE: begin
                for (idx = 0; idx < frame_limit(cfg_reserved_count); idx++)
                    set_frame_bit(idx, 1'b1);
                set_frame_bit(0, 1'b1);
            end
            MODE_ALLOC: begin
                for (w = 0; w * WORD_BITS < lim && !g.found; w++) begin
                    if (frame_used[w] != '1) begin
                        for (b = 0; b < WORD_BITS && !g.found; b++) begin
                            idx = w * WORD_BITS + b;
                            if (idx < lim && !frame_used[w][b]) begin
                                frame_used[w][b] = 1'b1;
                                g.found          = 1'b1;
                                g.frame_addr     = idx << FRAME_SHIFT;
                            end
                        end
                    end
                end
            end
            MODE_FREE_FRAME: begin
                idx = r.phys >> FRAME_SHIFT;
                if (idx < lim)
                    set_frame_bit(idx, 1'b0);
            end
            default: ;
        endcase
        return g;
    endfunction

    function automatic t_request make_request(logic [2:0] mode, logic [REGION_W-1:0] base,
                                              logic [REGION_W-1:0] length,
                                              logic [PHYS_W-1:0] phys);
        t_request r;
        r.mode   = mode;
        r.base   = base;
        r.length = length;
        r.phys   = phys;
        return r;
    endfunction

    // mostly allocate/free traffic inside the managed range, with noise in unused fields
    function automatic t_request random_request(int unsigned lim);
        t_request    r;
        int unsigned pick;
        int unsigned span;
        pick     = $urandom_range(99);
        span     = (lim == 0) ? 1 : lim;
        r.base   = {$urandom, $urandom};
        r.length = {$urandom, $urandom};
        r.phys   = $urandom;
        if (pick < 2) begin
            r.mode = MODE_INIT;
        end else if (pick < 42) begin
            r.mode = MODE_ALLOC;
        end else if (pick < 72) begin
            r.mode = MODE_FREE_FRAME;
            case ($urandom_range(9))
                0: ;
                1: r.phys = PHYS_W'(lim + $urandom_range(3)) << FRAME_SHIFT;
                default: r.phys = (PHYS_W'($urandom_range(span - 1)) << FRAME_SHIFT)
                                  | PHYS_W'($urandom_range(12'hFFF));
            endcase
        end else if (pick < 86) begin
            r.mode = MODE_FREE_REGION;
            case ($urandom_range(9))
                0: ;
                1: begin
                    r.base   = 64'hFFFF_FFFF_FFFF_FFFF - REGION_W'($urandom_range(8191));
                    r.length = REGION_W'($urandom_range(16'hFFFF));
                end
                default: begin
                    r.base   = REGION_W'($urandom_range(span - 1)) << FRAME_SHIFT;
                    r.length = REGION_W'($urandom_range(span / 4 + 1)) << FRAME_SHIFT;
                    if ($urandom_range(2) == 0)
                        r.base = r.base + REGION_W'($urandom_range(12'hFFF));
                    if ($urandom_range(2) == 0)
                        r.length = r.length + REGION_W'($urandom_range(12'hFFF));
                end
            endcase
        end else if (pick < 93) begin
            r.mode = MODE_RESERVE;
        end else begin
            r.mode = MODE_SPARE_FIRST + 3'($urandom_range(MODE_SPARE_LAST - MODE_SPARE_FIRST));
        end
        return r;
    endfunction

    // results are checked before the transaction of the same edge is predicted
    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            cfg_frame_count    = FRAME_COUNT_RST;
            cfg_reserved_count = RESERVED_COUNT_RST;
        end else begin
            if (o_valid) begin
                if (pending_grants.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result: frame_addr=%h found=%b",
                                 o_frame_addr, o_found);
                end else begin
                    want = pending_grants.pop_front();
                    if (o_frame_addr !== want.frame_addr || o_found !== want.found) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("mismatch at %0t: frame_addr exp %h got %h, found exp %b got %b",
                                     $realtime, want.frame_addr, o_frame_addr, want.found, o_found);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FRAME_COUNT:    cfg_frame_count    = i_cfg_data;
                    REG_RESERVED_COUNT: cfg_reserved_count = i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) begin
                pending_grants.push_back(predict_grant(make_request(i_mode, i_region_base,
                                                                    i_region_length, i_phys_addr)));
                req_taken = 1'b1;
            end
        end
    end

    always @(negedge i_clk) begin
        t_request r;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || req_taken) begin
            req_taken = 1'b0;
            if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
                r = pending_requests.pop_front();
                i_mode          <= r.mode;
                i_region_base   <= r.base;
                i_region_length <= r.length;
                i_phys_addr     <= r.phys;
                start           <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic drain_requests();
        while (pending_requests.size() != 0 || start || pending_grants.size() != 0
               || busy !== 1'b0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(int unsigned fc, int unsigned rc, int unsigned items,
                             int unsigned idle);
        int unsigned k;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_FRAME_COUNT;
        i_cfg_data <= CFG_W'(fc);
        @(negedge i_clk);
        i_cfg_idx  <= REG_RESERVED_COUNT;
        i_cfg_data <= CFG_W'(rc);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        idle_pct = idle;
        for (k = 0; k < items; k++)
            pending_requests.push_back(random_request(frame_limit(fc)));
        drain_requests();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = REG_FRAME_COUNT;
        i_cfg_data      = '0;
        start           = 1'b0;
        i_mode          = MODE_INIT;
        i_region_base   = '0;
        i_region_length = '0;
        i_phys_addr     = '0;
        req_taken       = 1'b0;
        idle_pct        = 0;
        fail_count      = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, at the reset sizes; the map must be initialised before anything reads it
        pending_requests.push_back(make_request(MODE_INIT, '0, '0, '0));
        pending_requests.push_back(make_request(MODE_ALLOC, '0, '0, '0));
        pending_requests.push_back(make_request(MODE_FREE_REGION, 64'h1001, 64'h3000, '0));
        pending_requests.push_back(make_request(MODE_ALLOC, '0, '0, '0));
        pending_requests.push_back(make_request(MODE_ALLOC, '0, '0, '0));
        pending_requests.push_back(make_request(MODE_ALLOC, '0, '0, '0));
        pending_requests.push_back(make_request(MODE_FREE_REGION, '0, '0, '0));
        pending_requests.push_back(make_request(MODE_FREE_REGION, 64'h5000, 64'h10, '0));
        pending_requests.push_back(make_request(MODE_FREE_REGION, 64'h9000,
                                                64'hFFFF_FFFF_FFFF_F000, '0));
        pending_requests.push_back(make_request(MODE_FREE_REGION, 64'hFFFF_FFFF_FFFF_F001,
                                                64'h2000, '0));
        pending_requests.push_back(make_request(MODE_ALLOC, '0, '0, '0));
        pending_requests.push_back(make_request(MODE_RESERVE, '0, '0, '0));
        pending_requests.push_back(make_request(MODE_FREE_REGION, '0, '1, '0));
        pending_requests.push_back(make_request(MODE_RESERVE, '0, '0, '0));
        pending_requests.push_back(make_request(MODE_ALLOC, '0, '0, '0));
        pending_requests.push_back(make_request(MODE_FREE_FRAME, '0, '0, 32'h0000_1FFF));
        pending_requests.push_back(make_request(MODE_ALLOC, '0, '0, '0));
        pending_requests.push_back(make_request(MODE_FREE_FRAME, '0, '0, 32'hFFFF_FFFF));
        pending_requests.push_back(make_request(MODE_FREE_FRAME, '0, '0, 32'h1000_0000));
        pending_requests.push_back(make_request(MODE_FREE_FRAME, '0, '0, 32'h0FFF_FFFF));
        pending_requests.push_back(make_request(MODE_SPARE_FIRST, '1, '1, '1));
        pending_requests.push_back(make_request(MODE_SPARE_FIRST + 3'd1, '1, '1, '1));
        pending_requests.push_back(make_request(MODE_SPARE_LAST, '1, '1, '1));
        pending_requests.push_back(make_request(MODE_FREE_REGION, 64'h0FFF_F000, 64'h1000, '0));
        pending_requests.push_back(make_request(MODE_FREE_REGION, '1, '1, '0));
        pending_requests.push_back(make_request(MODE_INIT, '0, '0, '0));
        drain_requests();

        run_phase(64, 3, 260, 0);
        run_phase(1, 0, 100, 52);
        run_phase(0, 131071, 60, 26);
        run_phase(1000, 40, 320, 0);
        run_phase(33, 32, 260, 52);
        run_phase(131071, 65536, 130, 26);
        run_phase(4096, 100, 400, 52);

        // catch any stray strobe after the last expected result
        repeat (50) @(negedge i_clk);
        if (fail_count == 0 && pending_grants.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #150_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
